/* hw/rtl/mihd_pkg.sv */
// Shared constants and types of the multi-input hysteresis debouncer.
package mihd_pkg;

	// Sizing of the sensor array
	localparam int NUM_SENSORS = 16;
	localparam int COUNT_BITS  = 4;
	localparam int NIB_W       = 4;
	localparam int DATA_W      = 16;
	localparam int CFG_W       = 64;
	localparam int CFG_IDX_W   = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ON_THRESHOLDS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_THRESHOLDS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK    = 2'd3;

	typedef logic [COUNT_BITS-1:0] count_t;

	// Full register set as seen by the datapath
	typedef struct packed {
		logic [CFG_W-1:0]  count_limits;
		logic [CFG_W-1:0]  on_thresholds;
		logic [CFG_W-1:0]  off_thresholds;
		logic [DATA_W-1:0] invert_mask;
	} cfg_regs_t;

	// Per-sensor slice of the register set
	typedef struct packed {
		count_t limit;
		count_t on_thr;
		count_t off_thr;
	} lane_cfg_t;

endpackage

/* hw/rtl/mihd_cfg_regs.sv */
// Configuration register file of the debouncer.
module mihd_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mihd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mihd_pkg::CFG_W-1:0]     cfg_data,
	output mihd_pkg::cfg_regs_t           regs
);

	mihd_pkg::cfg_regs_t regs_q;

	// Writes are taken in any cycle
	assign cfg_ready = 1'b1;

	// Register write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				mihd_pkg::REG_COUNT_LIMITS:   regs_q.count_limits   <= cfg_data;
				mihd_pkg::REG_ON_THRESHOLDS:  regs_q.on_thresholds  <= cfg_data;
				mihd_pkg::REG_OFF_THRESHOLDS: regs_q.off_thresholds <= cfg_data;
				mihd_pkg::REG_INVERT_MASK:
					regs_q.invert_mask <= cfg_data[mihd_pkg::DATA_W-1:0];
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

/* hw/rtl/mihd_lane.sv */
// One sensor's integrating counter and hysteresis flag.
module mihd_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic                raw,
	input  mihd_pkg::lane_cfg_t lcfg,
	output logic                flag_next
);

	mihd_pkg::count_t count_q;
	mihd_pkg::count_t count_n;
	logic             flag_q;

	// Saturating up/down count and threshold compare
	always_comb begin
		count_n   = count_q;
		flag_next = flag_q;
		if (raw) begin
			if (count_q < lcfg.limit) begin
				count_n = count_q + 1'b1;
			end
			if (count_n >= lcfg.on_thr) begin
				flag_next = 1'b1;
			end
		end else begin
			if (count_q != '0) begin
				count_n = count_q - 1'b1;
			end
			if (count_n <= lcfg.off_thr) begin
				flag_next = 1'b0;
			end
		end
	end

	// State update, once per request leaving the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			flag_q  <= 1'b0;
		end else if (advance) begin
			count_q <= count_n;
			flag_q  <= flag_next;
		end
	end

	// State only moves with a request
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(count_q) && $stable(flag_q)))
		else $error("lane state changed without a request");

	// A high sample below the limit counts up by exactly one
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && raw && (count_q < lcfg.limit)) |=> (count_q == $past(count_q) + 1'b1))
		else $error("lane counter did not step up");

	// A low sample at zero count always clears the flag
	a_clear_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !raw && (count_q == '0)) |=> !flag_q)
		else $error("flag still set at zero count");

endmodule

/* hw/rtl/multi_input_hysteresis_debouncer.sv */
// Top level of the multi-input hysteresis debouncer.
//
//  channel   dir   handshake              payload
//  s_*       in    s_tvalid / s_tready    s_tdata[15:0]   raw_levels
//  m_*       out   m_tvalid / m_tready    m_tdata[15:0]   filtered_levels
//  cfg_*     in    cfg_valid / cfg_ready  cfg_index[1:0], cfg_data[63:0]
//
// One request per cycle unless m_tready stalls; m_tvalid rises once the result register is loaded.
// The input register feeds all sensor lanes in parallel, the result register holds the output.
// arst_n clears all counters, flags, config registers and valid bits; everything passes raw levels.
// A stalled output keeps the input register full; s_tready drops only when both are held.
// cfg_ready is always high.
module multi_input_hysteresis_debouncer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [mihd_pkg::DATA_W-1:0]    s_tdata,   // [15:0] raw_levels
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [mihd_pkg::DATA_W-1:0]    m_tdata,   // [15:0] filtered_levels
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mihd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mihd_pkg::CFG_W-1:0]     cfg_data
);

	mihd_pkg::cfg_regs_t         regs;
	logic                        valid_s1;
	logic [mihd_pkg::DATA_W-1:0] raw_s1;
	logic                        valid_s2;
	logic [mihd_pkg::DATA_W-1:0] result_s2;
	logic [mihd_pkg::DATA_W-1:0] flags_next;
	logic                        advance;

	mihd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	// Stage handshake
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			raw_s1 <= s_tdata;
		end
	end

	// Sensor lanes; unused positions read as zero
	for (genvar i = 0; i < mihd_pkg::DATA_W; i++) begin : g_lane
		if (i < mihd_pkg::NUM_SENSORS) begin : g_used
			mihd_pkg::lane_cfg_t lcfg;
			assign lcfg.limit   =
				regs.count_limits[i*mihd_pkg::NIB_W +: mihd_pkg::COUNT_BITS];
			assign lcfg.on_thr  =
				regs.on_thresholds[i*mihd_pkg::NIB_W +: mihd_pkg::COUNT_BITS];
			assign lcfg.off_thr =
				regs.off_thresholds[i*mihd_pkg::NIB_W +: mihd_pkg::COUNT_BITS];

			mihd_lane u_lane (
				.clk       (clk),
				.arst_n    (arst_n),
				.advance   (advance),
				.raw       (raw_s1[i]),
				.lcfg      (lcfg),
				.flag_next (flags_next[i])
			);
		end else begin : g_unused
			assign flags_next[i] = 1'b0;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= flags_next ^ (regs.invert_mask &
				mihd_pkg::DATA_W'((1 << mihd_pkg::NUM_SENSORS) - 1));
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = result_s2;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the multi-input hysteresis debouncer.
`timescale 1ns / 100ps

module tb_top;
	import mihd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 64;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [DATA_W-1:0]    s_tdata;    // [15:0] raw_levels
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [DATA_W-1:0]    m_tdata;    // [15:0] filtered_levels
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// Predicted debouncer state and register copy
	logic [COUNT_BITS-1:0] lane_count [NUM_SENSORS];
	logic                  lane_flag  [NUM_SENSORS];
	logic [CFG_W-1:0]      limit_cfg;
	logic [CFG_W-1:0]      on_cfg;
	logic [CFG_W-1:0]      off_cfg;
	logic [DATA_W-1:0]     invert_cfg;

	logic [DATA_W-1:0] pending_filtered [$];
	logic [DATA_W-1:0] run_levels;
	int                err_cnt     = 0;
	int                cycle_cnt   = 0;
	bit                no_idle     = 1'b0;
	int                hold_reqs   = 0;
	int                hold_seen   = 0;
	int                hold_left   = 0;

	multi_input_hysteresis_debouncer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// One tick of the debouncer: update counters and flags, return reported levels
	function automatic logic [DATA_W-1:0] debounce_tick(input logic [DATA_W-1:0] raw);
		logic [DATA_W-1:0]     filtered;
		logic [COUNT_BITS-1:0] cnt;
		logic [COUNT_BITS-1:0] lim;
		logic [COUNT_BITS-1:0] on_thr;
		logic [COUNT_BITS-1:0] off_thr;
		filtered = '0;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			lim     = limit_cfg[NIB_W*i +: COUNT_BITS];
			on_thr  = on_cfg[NIB_W*i +: COUNT_BITS];
			off_thr = off_cfg[NIB_W*i +: COUNT_BITS];
			cnt     = lane_count[i];
			if (raw[i]) begin
				// above-limit count holds on a high sample
				if (cnt < lim)
					cnt = cnt + 1'b1;
				if (cnt >= on_thr)
					lane_flag[i] = 1'b1;
			end else begin
				if (cnt != '0)
					cnt = cnt - 1'b1;
				if (cnt <= off_thr)
					lane_flag[i] = 1'b0;
			end
			lane_count[i] = cnt;
			filtered[i]   = lane_flag[i] ^ invert_cfg[i];
		end
		return filtered;
	endfunction

	// Raw levels that mostly hold for long runs, with glitches and noise mixed in
	function automatic logic [DATA_W-1:0] next_raw_levels();
		logic [DATA_W-1:0] flips;
		flips = '0;
		for (int i = 0; i < DATA_W; i++)
			if ($urandom_range(0, 15) == 0)
				flips[i] = 1'b1;
		run_levels = run_levels ^ flips;
		case ($urandom_range(0, 7))
			0, 1: return DATA_W'($urandom);
			2: return run_levels ^ (DATA_W'(1) << $urandom_range(0, DATA_W - 1));
			default: return run_levels;
		endcase
	endfunction

	// Send one raw-level request; called and returns at a falling edge
	task automatic send_levels(input logic [DATA_W-1:0] raw);
		while (!no_idle && $urandom_range(0, 99) < 33) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= raw;
		do @(posedge clk); while (!s_tready);
		pending_filtered.push_back(debounce_tick(raw));
		@(negedge clk);
	endtask

	task automatic send_run(input int n);
		repeat (n) send_levels(next_raw_levels());
	endtask

	// Stop offering requests and wait for every outstanding result
	task automatic pause_until_drained();
		s_tvalid <= 1'b0;
		while (pending_filtered.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Register write request; block must be idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_COUNT_LIMITS:   limit_cfg  = val;
			REG_ON_THRESHOLDS:  on_cfg     = val;
			REG_OFF_THRESHOLDS: off_cfg    = val;
			REG_INVERT_MASK:    invert_cfg = val[DATA_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_settings(input logic [CFG_W-1:0] lim, input logic [CFG_W-1:0] on_t,
			input logic [CFG_W-1:0] off_t, input logic [CFG_W-1:0] inv);
		write_reg(REG_COUNT_LIMITS, lim);
		write_reg(REG_ON_THRESHOLDS, on_t);
		write_reg(REG_OFF_THRESHOLDS, off_t);
		write_reg(REG_INVERT_MASK, inv);
	endtask

	// Mostly ordered per sensor (off <= on <= limit), sometimes arbitrary
	task automatic load_random_settings();
		logic [CFG_W-1:0]      lim;
		logic [CFG_W-1:0]      on_t;
		logic [CFG_W-1:0]      off_t;
		logic [COUNT_BITS-1:0] l;
		logic [COUNT_BITS-1:0] o;
		logic [COUNT_BITS-1:0] f;
		for (int i = 0; i < CFG_W / NIB_W; i++) begin
			l = COUNT_BITS'($urandom_range(0, 15));
			if ($urandom_range(0, 3) == 0) begin
				o = COUNT_BITS'($urandom_range(0, 15));
				f = COUNT_BITS'($urandom_range(0, 15));
			end else begin
				o = COUNT_BITS'($urandom_range(0, l));
				f = COUNT_BITS'($urandom_range(0, o));
			end
			lim[NIB_W*i +: NIB_W]   = l;
			on_t[NIB_W*i +: NIB_W]  = o;
			off_t[NIB_W*i +: NIB_W] = f;
		end
		load_settings(lim, on_t, off_t, {$urandom, $urandom});
	endtask

	// All-zero registers after reset pass raw levels straight through
	task automatic test_reset_passthrough();
		send_levels(16'h0000);
		send_levels(16'hFFFF);
		send_levels(16'hA5A5);
		send_levels(16'h5A5A);
		send_levels(16'h0001);
		send_levels(16'h8000);
	endtask

	// Count up to the on threshold and back down to the off threshold, low half inverted
	task automatic test_hysteresis_extremes();
		pause_until_drained();
		load_settings({16{4'h4}}, {16{4'h3}}, {16{4'h1}}, 64'h0000_0000_0000_00FF);
		repeat (4) send_levels('1);
		repeat (4) send_levels('0);
	endtask

	// Lower the limit below a running count: highs hold it, lows still step it down
	task automatic test_count_above_limit();
		pause_until_drained();
		load_settings({16{4'hF}}, {16{4'h8}}, {16{4'h2}}, '0);
		repeat (6) send_levels('1);
		pause_until_drained();
		write_reg(REG_COUNT_LIMITS, {16{4'h2}});
		repeat (2) send_levels('1);
		repeat (2) send_levels('0);
	endtask

	// Phases of random levels under extreme and random register settings
	task automatic test_random_settings();
		for (int p = 0; p < 7; p++) begin
			pause_until_drained();
			case (p)
				0: load_settings('1, '1, '1, '1);
				1: load_settings('0, '0, '0, '0);
				default: load_random_settings();
			endcase
			// one phase runs at full rate on both sides
			no_idle = (p == 3);
			send_run(200);
		end
		no_idle = 1'b0;
	endtask

	// Receiver holds off while requests keep coming; sender pauses to drain
	task automatic test_backpressure();
		pause_until_drained();
		load_random_settings();
		hold_reqs++;
		send_run(100);
		pause_until_drained();
		send_run(100);
		hold_reqs++;
		send_run(100);
	endtask

	// Receiver: random stalls, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= no_idle || ($urandom_range(0, 99) >= 33);
		end
	end

	// Compare each result with the oldest prediction
	always @(posedge clk) begin : check_result
		logic [DATA_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_filtered.size() == 0) begin
				$error("filtered_levels: unexpected result, actual %h", m_tdata);
				err_cnt++;
			end else begin
				want = pending_filtered.pop_front();
				if (m_tdata !== want) begin
					$error("filtered_levels: expected %h actual %h", want, m_tdata);
					err_cnt++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_COUNT_LIMITS;
		cfg_data   = '0;
		run_levels = '0;
		limit_cfg  = '0;
		on_cfg     = '0;
		off_cfg    = '0;
		invert_cfg = '0;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			lane_count[i] = '0;
			lane_flag[i]  = 1'b0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_passthrough();
		test_hysteresis_extremes();
		test_count_above_limit();
		test_random_settings();
		test_backpressure();

		pause_until_drained();
		repeat (8) @(posedge clk);
		if (pending_filtered.size() != 0) begin
			$error("filtered_levels: %0d results never arrived", pending_filtered.size());
			err_cnt++;
		end
		if (err_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
